// ===== design/packbits_row_decoder_defines.svh =====
// Assertion macros for the files that carry checks (packbits_row_decoder.sv).
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PACKBITS_ROW_DECODER_DEFINES_SVH
`define PACKBITS_ROW_DECODER_DEFINES_SVH

// The consequent must hold at every edge where the antecedent holds.
`define PRD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packbits_row_decoder: implication check failed");

// The condition must never hold at a clock edge.
`define PRD_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("packbits_row_decoder: forbidden condition seen");

`endif

// ===== design/prd_pkg.sv =====
package prd_pkg;

    localparam int MAX_ROWS    = 4096;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
    localparam int LEN_W       = 15;
    localparam int CFG_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int ROWNUM_W    = 12;

    localparam logic [BYTE_W-1:0] SKIP_HEADER = 8'h80;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_ENTRY,
        OP_DATA
    } prd_op_t;

    typedef struct packed
    {
        prd_op_t           op;
        logic              last_entry;
        logic [ROW_W-1:0]  idx;
        logic [LEN_W-1:0]  val;
    } prd_item_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } prd_qstat_t;

endpackage

// ===== design/prd_if.sv =====
interface prd_stream_if;
    import prd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              channel_start;

    modport source (output valid, output in_byte, output channel_start, input ready);
    modport sink   (input valid, input in_byte, input channel_start, output ready);
endinterface

interface prd_result_if;
    import prd_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_value;
    logic [COUNT_W-1:0]  repeat_count;
    logic [ROWNUM_W-1:0] row_number;
    logic                row_last;
    logic                run_cut;

    modport source (output valid, output out_value, output repeat_count, output row_number,
                    output row_last, output run_cut, input ready);
    modport sink   (input valid, input out_value, input repeat_count, input row_number,
                    input row_last, input run_cut, output ready);
endinterface

interface prd_cfg_if;
    import prd_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] row_total;

    modport source (output valid, output row_total, input ready);
    modport sink   (input valid, input row_total, output ready);
endinterface

// ===== design/packbits_row_decoder.sv =====
// PackBits row decoder for one image channel. Bytes enter on the stream channel at up to one
// transfer per cycle; a byte marked channel_start begins the row-length table, whose entries
// (two bytes each, big-endian) are stored in an on-chip table, after which row data is decoded
// into value and repeat-count results, at most one per byte, on the result channel. In the
// steady state one byte is taken every cycle: the next row's length is always fetched ahead
// from the table's read port, so row ends cost nothing. Apart from stalls on the result
// channel, extra cycles come only from the table memory and row bookkeeping: loading the first
// row lengths after the last table entry (B_LOAD_FIRST, B_LOAD_NEXT), and skipping each
// empty row. A two-entry queue separates the byte intake from the decoder. The decoder holds
// each result in an output register and moves on to the next byte in the cycle that result is
// transferred; a byte passes through a queue slot before its result is registered. The length
// table is not cleared after reset; each channel writes the entries of its rows before they
// are used. The row_total register should only be written while idle.
`include "packbits_row_decoder_defines.svh"

module packbits_row_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    prd_stream_if.sink   stream,
    prd_result_if.source result,
    prd_cfg_if.sink      cfg
);
    import prd_pkg::*;

    logic [CFG_W-1:0]  row_total_reg;
    logic [CFG_W-1:0]  row_total_next;
    logic [ROWS_W-1:0] rows;
    logic              fifo_push;
    logic              fifo_pop;
    prd_item_t         fifo_in;
    prd_item_t         fifo_head;
    prd_qstat_t        fifo_stat;

    assign cfg.ready      = 1'b1;
    assign row_total_next = (cfg.valid && cfg.ready) ? cfg.row_total : row_total_reg;

    always_comb
    begin
        if (row_total_reg == '0)
        begin
            rows = ROWS_W'(1);
        end
        else if (32'(row_total_reg) > 32'(MAX_ROWS))
        begin
            rows = ROWS_W'(MAX_ROWS);
        end
        else
        begin
            rows = ROWS_W'(row_total_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_total_reg <= CFG_W'(1);
        end
        else
        begin
            row_total_reg <= row_total_next;
        end
    end

    prd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .rows      (rows),
        .qstat     (fifo_stat),
        .push      (fifo_push),
        .push_item (fifo_in)
    );

    prd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (fifo_in),
        .pop       (fifo_pop),
        .head      (fifo_head),
        .stat      (fifo_stat)
    );

    prd_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rows   (rows),
        .head   (fifo_head),
        .qstat  (fifo_stat),
        .pop    (fifo_pop),
        .result (result)
    );

    `PRD_ASSERT_NEVER(a_queue_overflow, fifo_push && fifo_stat.full && !fifo_pop)
    `PRD_ASSERT_IMPL(a_queue_underflow, fifo_pop, !fifo_stat.empty)
    `PRD_ASSERT_IMPL(a_empty_run_at_row_end, result.valid && (result.repeat_count == '0),
        result.row_last && result.run_cut)
    `PRD_ASSERT_IMPL(a_cut_only_at_row_end, result.valid && result.run_cut, result.row_last)
endmodule

// ===== design/prd_queue.sv =====
module prd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  prd_pkg::prd_item_t  push_item,
    input  logic                pop,
    output prd_pkg::prd_item_t  head,
    output prd_pkg::prd_qstat_t stat
);
    import prd_pkg::*;

    prd_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== design/prd_front.sv =====
module prd_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    prd_stream_if.sink                stream,
    input  logic [prd_pkg::ROWS_W-1:0] rows,
    input  prd_pkg::prd_qstat_t       qstat,
    output logic                      push,
    output prd_pkg::prd_item_t        push_item
);
    import prd_pkg::*;

    typedef enum logic [1:0]
    {
        F_HIGH,
        F_LOW,
        F_DATA
    } front_state_t;

    front_state_t      state_reg;
    front_state_t      state_next;
    front_state_t      state_eff;
    logic [ROW_W-1:0]  ptr_reg;
    logic [ROW_W-1:0]  ptr_next;
    logic [ROW_W-1:0]  ptr_eff;
    logic [ROWS_W-1:0] ptr_plus;
    logic [BYTE_W-1:0] hold_reg;
    logic [BYTE_W-1:0] hold_next;
    logic              accept;

    assign stream.ready = !qstat.full;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        state_eff  = stream.channel_start ? F_HIGH : state_reg;
        ptr_eff    = stream.channel_start ? '0 : ptr_reg;
        ptr_plus   = ROWS_W'(ptr_eff) + 1'b1;
        state_next = state_reg;
        ptr_next   = ptr_reg;
        hold_next  = hold_reg;
        push       = 1'b0;
        push_item.op         = OP_DATA;
        push_item.last_entry = 1'b0;
        push_item.idx        = ptr_eff;
        push_item.val        = LEN_W'(stream.in_byte);
        if (accept)
        begin
            ptr_next = ptr_eff;
            unique case (state_eff)
                F_HIGH:
                begin
                    hold_next  = stream.in_byte;
                    state_next = F_LOW;
                end
                F_LOW:
                begin
                    push                 = 1'b1;
                    push_item.op         = OP_ENTRY;
                    push_item.val        = hold_reg[BYTE_W-1] ? '0
                                           : {hold_reg[BYTE_W-2:0], stream.in_byte};
                    push_item.last_entry = (ptr_plus >= rows);
                    if (ptr_plus >= rows)
                    begin
                        state_next = F_DATA;
                        ptr_next   = '0;
                    end
                    else
                    begin
                        state_next = F_HIGH;
                        ptr_next   = ptr_plus[ROW_W-1:0];
                    end
                end
                F_DATA:
                begin
                    push = 1'b1;
                end
                default:
                begin
                    state_next = F_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_HIGH;
            ptr_reg   <= '0;
            hold_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            hold_reg  <= hold_next;
        end
    end
endmodule

// ===== design/prd_back.sv =====
module prd_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [prd_pkg::ROWS_W-1:0] rows,
    input  prd_pkg::prd_item_t         head,
    input  prd_pkg::prd_qstat_t        qstat,
    output logic                       pop,
    prd_result_if.source               result
);
    import prd_pkg::*;

    typedef enum logic [2:0]
    {
        B_TABLE,
        B_LOAD_FIRST,
        B_LOAD_NEXT,
        B_DATA,
        B_DONE
    } back_state_t;

    typedef enum logic [1:0]
    {
        RK_HEADER,
        RK_REPEAT,
        RK_LITERAL
    } run_kind_t;

    logic [LEN_W-1:0]    len_mem [MAX_ROWS];

    back_state_t         state_reg;
    back_state_t         state_next;
    run_kind_t           kind_reg;
    run_kind_t           kind_next;
    logic [ROWS_W-1:0]   cur_row_reg;
    logic [ROWS_W-1:0]   cur_row_next;
    logic [ROWS_W-1:0]   row_plus;
    logic [LEN_W-1:0]    row_left_reg;
    logic [LEN_W-1:0]    row_left_next;
    logic [LEN_W-1:0]    row_dec;
    logic [COUNT_W-1:0]  run_left_reg;
    logic [COUNT_W-1:0]  run_left_next;
    logic [COUNT_W-1:0]  run_left_dec;
    logic [COUNT_W-1:0]  run_count_reg;
    logic [COUNT_W-1:0]  run_count_next;
    logic [LEN_W-1:0]    rd_data_reg;
    logic                ahead_ok_reg;
    logic                ahead_ok_next;
    logic [LEN_W-1:0]    ahead;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic                out_free;
    logic                is_last;
    logic [BYTE_W-1:0]   b;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   out_value_reg;
    logic [BYTE_W-1:0]   out_value_next;
    logic [COUNT_W-1:0]  repeat_reg;
    logic [COUNT_W-1:0]  repeat_next;
    logic [ROWNUM_W-1:0] row_num_reg;
    logic [ROWNUM_W-1:0] row_num_next;
    logic                last_reg;
    logic                last_next;
    logic                cut_reg;
    logic                cut_next;

    assign result.valid        = out_valid_reg;
    assign result.out_value    = out_value_reg;
    assign result.repeat_count = repeat_reg;
    assign result.row_number   = row_num_reg;
    assign result.row_last     = last_reg;
    assign result.run_cut      = cut_reg;

    // Outside B_LOAD_FIRST, which reads row 0, the read port looks one row ahead of the row being decoded.
    assign ahead    = ahead_ok_reg ? rd_data_reg : '0;
    assign out_free = !out_valid_reg || result.ready;
    assign b        = head.val[BYTE_W-1:0];
    assign row_dec  = row_left_reg - 1'b1;
    assign is_last  = (row_dec == '0);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cur_row_next   = cur_row_reg;
        row_left_next  = row_left_reg;
        run_left_next  = run_left_reg;
        run_count_next = run_count_reg;
        run_left_dec   = (run_left_reg != '0) ? run_left_reg - 1'b1 : '0;
        pop            = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        repeat_next    = repeat_reg;
        row_num_next   = row_num_reg;
        last_next      = last_reg;
        cut_next       = cut_reg;

        unique case (state_reg) inside
            B_LOAD_FIRST:
            begin
                state_next = B_LOAD_NEXT;
            end
            B_LOAD_NEXT:
            begin
                row_left_next = rd_data_reg;
                state_next    = B_DATA;
            end
            B_TABLE, B_DATA, B_DONE:
            begin
                if (!qstat.empty)
                begin
                    if (head.op == OP_ENTRY)
                    begin
                        pop            = 1'b1;
                        wr_en          = 1'b1;
                        kind_next      = RK_HEADER;
                        run_left_next  = '0;
                        run_count_next = '0;
                        cur_row_next   = '0;
                        row_left_next  = '0;
                        state_next     = head.last_entry ? B_LOAD_FIRST : B_TABLE;
                    end
                    else if (state_reg != B_DATA)
                    begin
                        pop = 1'b1;
                    end
                    else if (cur_row_reg >= rows)
                    begin
                        pop        = 1'b1;
                        state_next = B_DONE;
                    end
                    else if (row_left_reg == '0)
                    begin
                        cur_row_next  = cur_row_reg + 1'b1;
                        row_left_next = ahead;
                        kind_next     = RK_HEADER;
                    end
                    else if (out_free)
                    begin
                        pop = 1'b1;
                        if (is_last)
                        begin
                            cur_row_next  = cur_row_reg + 1'b1;
                            row_left_next = ahead;
                        end
                        else
                        begin
                            row_left_next = row_dec;
                        end
                        row_num_next = cur_row_reg[ROWNUM_W-1:0];
                        last_next    = is_last;
                        unique case (kind_reg)
                            RK_HEADER:
                            begin
                                if (b != SKIP_HEADER)
                                begin
                                    if (b > SKIP_HEADER)
                                    begin
                                        kind_next      = RK_REPEAT;
                                        run_count_next = COUNT_W'(9'd257 - {1'b0, b});
                                    end
                                    else
                                    begin
                                        kind_next     = RK_LITERAL;
                                        run_left_next = b + 1'b1;
                                    end
                                    if (is_last)
                                    begin
                                        kind_next      = RK_HEADER;
                                        out_valid_next = 1'b1;
                                        out_value_next = '0;
                                        repeat_next    = '0;
                                        cut_next       = 1'b1;
                                    end
                                end
                            end
                            RK_REPEAT:
                            begin
                                kind_next      = RK_HEADER;
                                out_valid_next = 1'b1;
                                out_value_next = b;
                                repeat_next    = run_count_reg;
                                cut_next       = 1'b0;
                            end
                            RK_LITERAL:
                            begin
                                run_left_next = run_left_dec;
                                if (run_left_dec == '0 || is_last)
                                begin
                                    kind_next     = RK_HEADER;
                                    run_left_next = '0;
                                end
                                out_valid_next = 1'b1;
                                out_value_next = b;
                                repeat_next    = COUNT_W'(1);
                                cut_next       = is_last && (run_left_reg > COUNT_W'(1));
                            end
                            default:
                            begin
                                kind_next = RK_HEADER;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = B_TABLE;
            end
        endcase

        row_plus      = cur_row_next + 1'b1;
        ahead_ok_next = (row_plus < ROWS_W'(MAX_ROWS));
        rd_addr       = (state_reg == B_LOAD_FIRST) ? '0 : row_plus[ROW_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            len_mem[head.idx] <= head.val;
        end
        rd_data_reg <= len_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_TABLE;
            kind_reg      <= RK_HEADER;
            cur_row_reg   <= '0;
            row_left_reg  <= '0;
            run_left_reg  <= '0;
            run_count_reg <= '0;
            ahead_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            repeat_reg    <= '0;
            row_num_reg   <= '0;
            last_reg      <= 1'b0;
            cut_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            cur_row_reg   <= cur_row_next;
            row_left_reg  <= row_left_next;
            run_left_reg  <= run_left_next;
            run_count_reg <= run_count_next;
            ahead_ok_reg  <= ahead_ok_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            repeat_reg    <= repeat_next;
            row_num_reg   <= row_num_next;
            last_reg      <= last_next;
            cut_reg       <= cut_next;
        end
    end
endmodule

// ===== verif/tb_packbits_row_decoder.sv =====
module tb_packbits_row_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;

    localparam int SPARSE_ROWS = 160;

    typedef enum logic [1:0]
    {
        TABLE_HIGH,
        TABLE_LOW,
        ROW_DATA,
        CHANNEL_DONE
    } phase_t;

    typedef enum logic [1:0]
    {
        EXPECT_HEADER,
        IN_REPEAT,
        IN_LITERAL
    } run_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0]   value;
        logic [COUNT_W-1:0]  count;
        logic [ROWNUM_W-1:0] row;
        logic                last;
        logic                cut;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n;

    prd_stream_if stream_bus();
    prd_result_if result_bus();
    prd_cfg_if    cfg_bus();

    packbits_row_decoder DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #2 clk = ~clk;

    decoded_t          decoded_q[$];
    int                errors = 0;
    int                useful_bytes = 0;
    int                burst_left = 0;
    bit                gaps_on = 1'b1;
    int                hold_cycles = 0;

    logic [15:0]       chan_len[$];
    logic [BYTE_W-1:0] chan_data[$];

    logic [CFG_W-1:0]  row_total_reg;
    phase_t            dec_phase;
    logic [LEN_W-1:0]  length_mem [MAX_ROWS];
    int                table_ptr;
    logic [BYTE_W-1:0] high_hold;
    int                cur_row;
    int                row_left;
    run_t              run_state;
    int                literal_left;
    int                run_len;

    function automatic int rows_active();
        int r;
        r = row_total_reg;
        if (r == 0)
            r = 1;
        if (r > MAX_ROWS)
            r = MAX_ROWS;
        return r;
    endfunction

    function automatic int length_at(input int i);
        return (i < MAX_ROWS) ? int'(length_mem[i]) : 0;
    endfunction

    task automatic clear_channel();
        dec_phase    = TABLE_HIGH;
        table_ptr    = 0;
        high_hold    = '0;
        cur_row      = 0;
        row_left     = 0;
        run_state    = EXPECT_HEADER;
        literal_left = 0;
        run_len      = 0;
    endtask

    task automatic push_result(input int v, input int c, input int r, input bit l, input bit ct);
        decoded_t d;
        d.value = BYTE_W'(v);
        d.count = COUNT_W'(c);
        d.row   = ROWNUM_W'(r);
        d.last  = l;
        d.cut   = ct;
        decoded_q.push_back(d);
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic start);
        int rows;
        int row;
        bit last;
        bit cut;
        rows = rows_active();
        if (start)
            clear_channel();
        if (dec_phase != CHANNEL_DONE)
            useful_bytes++;
        case (dec_phase)
            TABLE_HIGH:
            begin
                high_hold = b;
                dec_phase = TABLE_LOW;
            end
            TABLE_LOW:
            begin
                if (table_ptr < MAX_ROWS)
                    length_mem[table_ptr] = high_hold[7] ? '0 : {high_hold[6:0], b};
                table_ptr++;
                if (table_ptr >= rows)
                begin
                    dec_phase = ROW_DATA;
                    cur_row   = 0;
                    row_left  = length_at(0);
                    run_state = EXPECT_HEADER;
                end
                else
                begin
                    dec_phase = TABLE_HIGH;
                end
            end
            ROW_DATA:
            begin
                while (cur_row < rows && row_left == 0)
                begin
                    cur_row++;
                    row_left  = length_at(cur_row);
                    run_state = EXPECT_HEADER;
                end
                if (cur_row >= rows)
                begin
                    dec_phase = CHANNEL_DONE;
                    return;
                end
                row = cur_row;
                row_left--;
                last = (row_left == 0);
                if (last)
                begin
                    cur_row++;
                    row_left = length_at(cur_row);
                end
                case (run_state)
                    EXPECT_HEADER:
                    begin
                        if (b == SKIP_HEADER)
                            return;
                        if (b > SKIP_HEADER)
                        begin
                            run_state = IN_REPEAT;
                            run_len   = 257 - int'(b);
                        end
                        else
                        begin
                            run_state    = IN_LITERAL;
                            literal_left = int'(b) + 1;
                        end
                        if (last)
                        begin
                            run_state = EXPECT_HEADER;
                            push_result(0, 0, row, 1'b1, 1'b1);
                        end
                    end
                    IN_REPEAT:
                    begin
                        run_state = EXPECT_HEADER;
                        push_result(b, run_len, row, last, 1'b0);
                    end
                    IN_LITERAL:
                    begin
                        cut = last && literal_left > 1;
                        if (literal_left > 0)
                            literal_left--;
                        if (literal_left == 0 || last)
                        begin
                            run_state    = EXPECT_HEADER;
                            literal_left = 0;
                        end
                        push_result(b, 1, row, last, cut);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                stream_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        stream_bus.valid         <= 1'b1;
        stream_bus.in_byte       <= b;
        stream_bus.channel_start <= start;
        @(posedge clk);
        while (!stream_bus.ready)
            @(posedge clk);
        predict_byte(b, start);
        burst_left--;
    endtask

    task automatic wait_idle();
        stream_bus.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (rows_active() + 40) @(posedge clk);
    endtask

    task automatic write_row_total(input logic [CFG_W-1:0] v);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.row_total <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        row_total_reg = v;
    endtask

    // The channel is sent as its table, the row data and extra_bytes random bytes; a nonzero stop_after
    // cuts it short so that the next channel_start lands in the middle.
    task automatic send_channel(input int extra_bytes, input int stop_after);
        logic [BYTE_W-1:0] bytes_q[$];
        int k;
        foreach (chan_len[i])
        begin
            bytes_q.push_back(chan_len[i][15:8]);
            bytes_q.push_back(chan_len[i][7:0]);
        end
        foreach (chan_data[i])
            bytes_q.push_back(chan_data[i]);
        repeat (extra_bytes) bytes_q.push_back(BYTE_W'($urandom));
        for (k = 0; k < bytes_q.size(); k++)
        begin
            if (stop_after > 0 && k >= stop_after)
                break;
            send_byte(bytes_q[k], k == 0);
        end
        chan_len.delete();
        chan_data.delete();
    endtask

    task automatic add_row();
        int first;
        int mode;
        int n;
        first = chan_data.size();
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            chan_len.push_back(16'd0);
        end
        else if (mode == 1)
        begin
            chan_len.push_back(16'h8000 | 16'($urandom_range(0, 32767)));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9)) inside
                    0: chan_data.push_back(SKIP_HEADER);
                    [1:4]:
                    begin
                        chan_data.push_back(BYTE_W'($urandom_range(129, 255)));
                        chan_data.push_back(BYTE_W'($urandom));
                    end
                    default:
                    begin
                        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                         : $urandom_range(0, 7);
                        chan_data.push_back(BYTE_W'(n));
                        repeat (n + 1) chan_data.push_back(BYTE_W'($urandom));
                    end
                endcase
            end
            if (mode == 2)
                repeat ($urandom_range(1, chan_data.size() - first)) void'(chan_data.pop_back());
            chan_len.push_back(16'(chan_data.size() - first));
        end
    endtask

    task automatic send_sparse_channel(input int n_rows);
        int i;
        for (i = 0; i < n_rows; i++)
        begin
            if (i == 0 || i == n_rows / 2 || i == n_rows - 1)
            begin
                chan_len.push_back(16'd2);
                chan_data.push_back(BYTE_W'($urandom_range(129, 255)));
                chan_data.push_back(BYTE_W'($urandom));
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                chan_len.push_back(16'h8000 | 16'($urandom_range(0, 32767)));
            end
            else
            begin
                chan_len.push_back(16'd0);
            end
        end
        send_channel(1, 0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic test_directed_packets();
        wait_idle();
        write_row_total(CFG_W'(4));
        chan_len  = {16'd6, 16'd0, 16'd4, 16'd1};
        chan_data = {8'h80, 8'hFE, 8'hAA, 8'h01, 8'h00, 8'hFF,
                     8'h81, 8'h55, 8'h7F, 8'h12,
                     8'h03};
        send_channel(2, 0);
    endtask

    task automatic test_directed_restart();
        int pass;
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h7F, 1'b0);
        for (pass = 0; pass < 2; pass++)
        begin
            chan_len  = {16'h8005, 16'h0001, 16'h0002, 16'h0003};
            chan_data = {8'h80, 8'hFF, 8'h00, 8'h01, 8'hC3, 8'h3C};
            send_channel(pass, (pass == 0) ? 11 : 0);
        end
    endtask

    task automatic test_row_total_extremes();
        wait_idle();
        write_row_total('0);
        chan_len  = {16'd3};
        chan_data = {8'h7F, 8'h01, 8'h02};
        send_channel(2, 0);
        wait_idle();
        write_row_total(CFG_W'(SPARSE_ROWS));
        send_sparse_channel(SPARSE_ROWS);
    endtask

    task automatic test_output_stall();
        wait_idle();
        write_row_total(CFG_W'(1));
        gaps_on = 1'b0;
        repeat (80)
        begin
            chan_data.push_back(BYTE_W'($urandom_range(129, 255)));
            chan_data.push_back(BYTE_W'($urandom));
        end
        chan_len.push_back(16'(chan_data.size()));
        hold_cycles = 400;
        send_channel(0, 0);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_channels();
        int k;
        useful_bytes = 0;
        while (useful_bytes < 850)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0)
            begin
                wait_idle();
                write_row_total(($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(1, 64))
                                                             : CFG_W'($urandom_range(1, 12)));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                k = $urandom_range(10, 60);
                for (int i = 0; i < k; i++)
                    send_byte(BYTE_W'($urandom), i == 0 || $urandom_range(0, 29) == 0);
            end
            else
            begin
                repeat (rows_active()) add_row();
                send_channel(($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * rows_active() + 8)
                                                          : 0);
            end
        end
    endtask

    initial
    begin
        decoded_t want;
        int pct;
        int span;
        pct  = 0;
        span = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0d/%0d",
                             $time, result_bus.out_value, result_bus.repeat_count,
                             result_bus.row_number);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("out_value", 16'(want.value), 16'(result_bus.out_value));
                    check_field("repeat_count", 16'(want.count), 16'(result_bus.repeat_count));
                    check_field("row_number", 16'(want.row), 16'(result_bus.row_number));
                    check_field("row_last", 16'(want.last), 16'(result_bus.row_last));
                    check_field("run_cut", 16'(want.cut), 16'(result_bus.run_cut));
                end
            end
            if (span == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pct = 0;
                    1: pct = 20;
                    2: pct = 50;
                    default: pct = 85;
                endcase
                span = $urandom_range(64, 256);
            end
            span--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    initial
    begin
        rst_n                    <= 1'b0;
        stream_bus.valid         <= 1'b0;
        stream_bus.in_byte       <= '0;
        stream_bus.channel_start <= 1'b0;
        cfg_bus.valid            <= 1'b0;
        cfg_bus.row_total        <= '0;
        row_total_reg = CFG_W'(1);
        foreach (length_mem[i])
            length_mem[i] = '0;
        clear_channel();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_packets();
        test_directed_restart();
        test_row_total_extremes();
        test_output_stall();
        test_random_channels();
        wait_idle();
        if (errors == 0 && decoded_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
